// ===== rtl/core/jit_pkg.sv =====
// Package for the 3x3 Jacobian inverse-transpose pipeline.
// Holds widths, the adjugate operand table, lane flag types and the rounding helper.
// No dependencies.
package jit_pkg;

	localparam int W         = 32;
	localparam int PC_W      = 163;
	localparam int DIV_STEPS = 33;
	localparam int LAT       = 42;

	// Operand indexes per adjugate entry: a*b - c*d.
	// Jacobian order: j11 j21 j31 j12 j22 j32 j13 j23 j33.
	localparam logic [3:0] ADJ_IDX [0:8][0:3] = '{
		'{4'd4, 4'd8, 4'd7, 4'd5},
		'{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd0, 4'd8, 4'd6, 4'd2},
		'{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6},
		'{4'd1, 4'd6, 4'd0, 4'd7},
		'{4'd0, 4'd4, 4'd3, 4'd1}
	};

	typedef struct packed {
		logic neg;
		logic zero;
	} dflag_t;

	// Q80.80 to Q16.16, round half away from zero, saturate.
	function automatic logic [W-1:0] round_sat(input logic [PC_W-1:0] x);
		logic [PC_W-1:0] r;
		logic [98:0]     y;
		logic            fits;
		r    = x + (x[PC_W-1] ? PC_W'(64'h7FFF_FFFF_FFFF_FFFF) : PC_W'(64'h8000_0000_0000_0000));
		y    = r[PC_W-1:64];
		fits = (&y[98:31]) | ~(|y[98:31]);
		if (fits)
			round_sat = y[31:0];
		else if (y[98])
			round_sat = 32'h8000_0000;
		else
			round_sat = 32'h7FFF_FFFF;
	endfunction

endpackage

// ===== rtl/core/jit_div_lane.sv =====
// One divider lane: rounded |adj| * 2^32 / |det|, one quotient bit per stage, signed, saturated, zero for det 0.
// Depends on jit_pkg.
module jit_div_lane (
	input  logic                   clk,
	input  logic [63:0]            num_mag,
	input  logic [97:0]            den_mag,
	input  jit_pkg::dflag_t        flg,
	output logic [jit_pkg::W-1:0]  quo,
	output jit_pkg::dflag_t        flg_out
);

	localparam int N = jit_pkg::DIV_STEPS;

	logic [97:0]     num_c;
	logic [98:0]     rem_s [0:N];
	logic [32:0]     low_s [0:N];
	logic [32:0]     qt_s  [0:N];
	logic [98:0]     den_s [0:N];
	logic            ovf_s [0:N];
	jit_pkg::dflag_t flg_s [0:N];

	// numerator 2*|adj|*2^32 + |det|, denominator 2*|det|
	assign num_c = 98'({num_mag, 33'b0}) + 98'(den_mag);

	always_ff @(posedge clk) begin
		rem_s[0] <= 99'(num_c[97:33]);
		low_s[0] <= num_c[32:0];
		den_s[0] <= {den_mag, 1'b0};
		ovf_s[0] <= ({34'b0, num_c[97:33]} >= {den_mag, 1'b0});
		qt_s[0]  <= '0;
		flg_s[0] <= flg;
	end

	for (genvar i = 1; i <= N; i++) begin : g_step
		logic [99:0] trial;
		logic [99:0] diff;
		logic        ge;
		assign trial = {rem_s[i-1], low_s[i-1][32]};
		assign diff  = trial - {1'b0, den_s[i-1]};
		assign ge    = trial >= {1'b0, den_s[i-1]};
		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? diff[98:0] : trial[98:0];
			low_s[i] <= {low_s[i-1][31:0], 1'b0};
			qt_s[i]  <= {qt_s[i-1][31:0], ge};
			den_s[i] <= den_s[i-1];
			ovf_s[i] <= ovf_s[i-1];
			flg_s[i] <= flg_s[i-1];
		end
	end

	always_comb begin
		if (flg_s[N].zero)
			quo = '0;
		else if (!flg_s[N].neg)
			quo = (ovf_s[N] || qt_s[N][32] || qt_s[N][31]) ? 32'h7FFF_FFFF : qt_s[N][31:0];
		else if (ovf_s[N] || qt_s[N][32] || (qt_s[N][31] && (|qt_s[N][30:0])))
			quo = 32'h8000_0000;
		else
			quo = 32'(-qt_s[N][31:0]);
	end

	assign flg_out = flg_s[N];

endmodule

// ===== rtl/core/jacobian_inverse_transpose_3x3.sv =====
// Top level: 3x3 Jacobian inverse transpose and coefficient scaling, fully pipelined.
// Depends on jit_pkg and jit_div_lane.
//
//  channel | handshake      | payload
//  --------+----------------+-------------------------------------------------
//  in      | start / busy   | jac_r*c*, quad_weight, coef_first, coef_second
//  out     | done (strobe)  | slot0..slot8 *_over_det, scaled_first/second
//
// One transaction per cycle; 42 register stages: seven front stages, the divider
// input register and its 33 one-bit stages, and the output register. done is the
// last stage of the valid chain and rises with the result in the output register.
// busy is always low; the receiver cannot stall, so the pipe never holds.
// arst_n clears the valid chain only.
module jacobian_inverse_transpose_3x3 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] jac_r1c1,
	input  logic signed [31:0] jac_r2c1,
	input  logic signed [31:0] jac_r3c1,
	input  logic signed [31:0] jac_r1c2,
	input  logic signed [31:0] jac_r2c2,
	input  logic signed [31:0] jac_r3c2,
	input  logic signed [31:0] jac_r1c3,
	input  logic signed [31:0] jac_r2c3,
	input  logic signed [31:0] jac_r3c3,
	input  logic signed [31:0] quad_weight,
	input  logic signed [31:0] coef_first,
	input  logic signed [31:0] coef_second,
	output logic               done,
	output logic signed [31:0] slot0_a11_over_det,
	output logic signed [31:0] slot1_a21_over_det,
	output logic signed [31:0] slot2_a31_over_det,
	output logic signed [31:0] slot3_a12_over_det,
	output logic signed [31:0] slot4_a22_over_det,
	output logic signed [31:0] slot5_a32_over_det,
	output logic signed [31:0] slot6_a13_over_det,
	output logic signed [31:0] slot7_a23_over_det,
	output logic signed [31:0] slot8_a33_over_det,
	output logic signed [31:0] scaled_first,
	output logic signed [31:0] scaled_second
);

	localparam int LAT = jit_pkg::LAT;

	logic                    vld_s [1:LAT];
	logic signed [31:0]      j_s1  [0:8];
	logic signed [31:0]      jd_s  [2:3][0:2];
	logic signed [31:0]      w_s   [1:6];
	logic signed [31:0]      c_s   [1:8][0:1];
	logic signed [63:0]      pp_s2 [0:8][0:1];
	logic signed [64:0]      adj_s [3:6][0:8];
	logic signed [65:0]      dl_s4 [0:2];
	logic signed [63:0]      dh_s4 [0:2];
	logic signed [96:0]      term_s5 [0:2];
	logic signed [98:0]      det_s6;
	logic [63:0]             amag_s7 [0:8];
	logic [97:0]             dmag_s7;
	jit_pkg::dflag_t         flg_s7 [0:8];
	logic signed [65:0]      wp_s7 [0:2];
	logic signed [130:0]     p_s8;
	logic signed [65:0]      cp_s9 [0:1][0:3];
	logic [162:0]            x_s10 [0:1];
	logic [31:0]             sc_s  [11:41][0:1];
	logic [31:0]             quo   [0:8];
	jit_pkg::dflag_t         flg_o [0:8];
	logic [31:0]             res_s42 [0:10];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[1] <= start && !busy;
			for (int i = 2; i <= LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		j_s1[0] <= jac_r1c1;
		j_s1[1] <= jac_r2c1;
		j_s1[2] <= jac_r3c1;
		j_s1[3] <= jac_r1c2;
		j_s1[4] <= jac_r2c2;
		j_s1[5] <= jac_r3c2;
		j_s1[6] <= jac_r1c3;
		j_s1[7] <= jac_r2c3;
		j_s1[8] <= jac_r3c3;
		w_s[1]    <= quad_weight;
		c_s[1][0] <= coef_first;
		c_s[1][1] <= coef_second;
		for (int i = 2; i <= 6; i++) w_s[i] <= w_s[i-1];
		for (int i = 2; i <= 8; i++) c_s[i] <= c_s[i-1];

		// s2: cofactor products
		for (int k = 0; k < 9; k++) begin
			pp_s2[k][0] <= j_s1[jit_pkg::ADJ_IDX[k][0]] * j_s1[jit_pkg::ADJ_IDX[k][1]];
			pp_s2[k][1] <= j_s1[jit_pkg::ADJ_IDX[k][2]] * j_s1[jit_pkg::ADJ_IDX[k][3]];
		end
		for (int t = 0; t < 3; t++) jd_s[2][t] <= j_s1[t];
		jd_s[3] <= jd_s[2];

		// s3: adjugate
		for (int k = 0; k < 9; k++)
			adj_s[3][k] <= 65'(pp_s2[k][0]) - 65'(pp_s2[k][1]);
		for (int i = 4; i <= 6; i++) adj_s[i] <= adj_s[i-1];

		// s4: determinant partial products, first column against A11 A12 A13
		for (int t = 0; t < 3; t++) begin
			dl_s4[t] <= $signed({1'b0, adj_s[3][3*t][32:0]}) * jd_s[3][t];
			dh_s4[t] <= $signed(adj_s[3][3*t][64:33]) * jd_s[3][t];
		end

		// s5, s6: determinant Q48.48
		for (int t = 0; t < 3; t++)
			term_s5[t] <= {dh_s4[t], 33'b0} + 97'(dl_s4[t]);
		det_s6 <= 99'(term_s5[0]) + 99'(term_s5[1]) + 99'(term_s5[2]);

		// s7: magnitudes and signs for the dividers; det * w partials
		for (int k = 0; k < 9; k++) begin
			amag_s7[k]     <= adj_s[6][k][64] ? 64'(-adj_s[6][k]) : adj_s[6][k][63:0];
			flg_s7[k].neg  <= adj_s[6][k][64] ^ det_s6[98];
			flg_s7[k].zero <= (det_s6 == '0);
		end
		dmag_s7  <= det_s6[98] ? 98'(-det_s6) : det_s6[97:0];
		wp_s7[0] <= $signed({1'b0, det_s6[32:0]}) * w_s[6];
		wp_s7[1] <= $signed({1'b0, det_s6[65:33]}) * w_s[6];
		wp_s7[2] <= $signed(det_s6[98:66]) * w_s[6];

		// s8: det * w, Q64.64
		p_s8 <= 131'(wp_s7[0]) + (131'(wp_s7[1]) <<< 33) + (131'(wp_s7[2]) <<< 66);

		// s9, s10: times coefficient, Q80.80
		for (int e = 0; e < 2; e++) begin
			cp_s9[e][0] <= $signed({1'b0, p_s8[32:0]}) * c_s[8][e];
			cp_s9[e][1] <= $signed({1'b0, p_s8[65:33]}) * c_s[8][e];
			cp_s9[e][2] <= $signed({1'b0, p_s8[98:66]}) * c_s[8][e];
			cp_s9[e][3] <= $signed(p_s8[130:99]) * c_s[8][e];
			x_s10[e] <= 163'(cp_s9[e][0]) + (163'(cp_s9[e][1]) <<< 33)
				+ (163'(cp_s9[e][2]) <<< 66) + (163'(cp_s9[e][3]) <<< 99);
			sc_s[11][e] <= jit_pkg::round_sat(x_s10[e]);
		end
		for (int i = 12; i <= 41; i++) sc_s[i] <= sc_s[i-1];

		// s42: output register
		for (int k = 0; k < 9; k++) res_s42[k] <= quo[k];
		res_s42[9]  <= sc_s[41][0];
		res_s42[10] <= sc_s[41][1];
	end

	for (genvar k = 0; k < 9; k++) begin : g_div
		jit_div_lane u_lane (
			.clk     (clk),
			.num_mag (amag_s7[k]),
			.den_mag (dmag_s7),
			.flg     (flg_s7[k]),
			.quo     (quo[k]),
			.flg_out (flg_o[k])
		);
	end

	assign done               = vld_s[LAT];
	assign slot0_a11_over_det = res_s42[0];
	assign slot1_a21_over_det = res_s42[1];
	assign slot2_a31_over_det = res_s42[2];
	assign slot3_a12_over_det = res_s42[3];
	assign slot4_a22_over_det = res_s42[4];
	assign slot5_a32_over_det = res_s42[5];
	assign slot6_a13_over_det = res_s42[6];
	assign slot7_a23_over_det = res_s42[7];
	assign slot8_a33_over_det = res_s42[8];
	assign scaled_first       = res_s42[9];
	assign scaled_second      = res_s42[10];

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without matching transaction");

	a_zero_det: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAT-1] && flg_o[0].zero |=> slot0_a11_over_det == 0
			&& slot8_a33_over_det == 0 && scaled_first == 0 && scaled_second == 0)
		else $error("singular Jacobian gave nonzero result");

	a_lane_flags: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAT-1] |-> flg_o[0].zero == flg_o[4].zero && flg_o[0].zero == flg_o[8].zero)
		else $error("divider lanes out of step");

endmodule

// ===== test/jacobian_inverse_transpose_3x3_tb.sv =====
// Testbench for jacobian_inverse_transpose_3x3: directed and random quadrature points,
// an in-bench predictor of adjugate over determinant and scaled coefficients.
// Depends on jit_pkg and the RTL of the block.
`timescale 1ns / 1ps

module jacobian_inverse_transpose_3x3_tb;

	typedef logic [11:0][31:0] point_t;
	typedef logic [10:0][31:0] inv_t;

	class inv_scoreboard;
		inv_t expected_q[$];
		int   errors;
		int   checked;

		function logic [31:0] saturate(input logic neg, input logic [191:0] mag);
			if (!neg)
				return (mag > 192'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
			if (mag > 192'h8000_0000)
				return 32'h8000_0000;
			return 32'h0 - mag[31:0];
		endfunction

		function logic signed [191:0] sx(input logic [31:0] v);
			return {{160{v[31]}}, v};
		endfunction

		function logic [191:0] mag_of(input logic signed [191:0] v);
			return v[191] ? -v : v;
		endfunction

		function logic [31:0] round_scaled(input logic signed [191:0] p);
			logic [191:0] m;
			m = mag_of(p) + (192'h1 << 63);
			return saturate(p[191], m >> 64);
		endfunction

		function inv_t predict_inverse(input point_t pt);
			logic signed [191:0] j [9];
			logic signed [191:0] adj [9];
			logic signed [191:0] det, pw;
			logic [191:0] dabs, num;
			inv_t r;
			for (int i = 0; i < 9; i++)
				j[i] = sx(pt[i]);
			adj[0] = j[4] * j[8] - j[7] * j[5];
			adj[1] = j[2] * j[7] - j[1] * j[8];
			adj[2] = j[1] * j[5] - j[2] * j[4];
			adj[3] = j[5] * j[6] - j[3] * j[8];
			adj[4] = j[0] * j[8] - j[6] * j[2];
			adj[5] = j[2] * j[3] - j[0] * j[5];
			adj[6] = j[3] * j[7] - j[4] * j[6];
			adj[7] = j[1] * j[6] - j[0] * j[7];
			adj[8] = j[0] * j[4] - j[3] * j[1];
			det  = adj[0] * j[0] + adj[3] * j[1] + adj[6] * j[2];
			dabs = mag_of(det);
			for (int k = 0; k < 9; k++) begin
				if (det == 0) begin
					r[k] = '0;
				end else begin
					num  = ((mag_of(adj[k]) << 32) << 1) + dabs;
					r[k] = saturate(adj[k][191] != det[191], num / (dabs << 1));
				end
			end
			pw    = det * sx(pt[9]);
			r[9]  = round_scaled(pw * sx(pt[10]));
			r[10] = round_scaled(pw * sx(pt[11]));
			return r;
		endfunction

		function void note_point(input point_t pt);
			expected_q.push_back(predict_inverse(pt));
		endfunction

		task report(input string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_result(input inv_t got);
			inv_t exp_r;
			if (expected_q.size() == 0) begin
				report("result with no transaction outstanding");
				return;
			end
			exp_r = expected_q.pop_front();
			checked++;
			for (int k = 0; k < 11; k++)
				if (got[k] !== exp_r[k])
					report($sformatf("result %0d field %0d: got %h expected %h",
						checked, k, got[k], exp_r[k]));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	point_t pt_in;
	inv_t   res_out;
	inv_scoreboard sb;
	int idle_pct;
	int sent;

	jacobian_inverse_transpose_3x3 uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.jac_r1c1(pt_in[0]), .jac_r2c1(pt_in[1]), .jac_r3c1(pt_in[2]),
		.jac_r1c2(pt_in[3]), .jac_r2c2(pt_in[4]), .jac_r3c2(pt_in[5]),
		.jac_r1c3(pt_in[6]), .jac_r2c3(pt_in[7]), .jac_r3c3(pt_in[8]),
		.quad_weight(pt_in[9]), .coef_first(pt_in[10]), .coef_second(pt_in[11]),
		.done(done),
		.slot0_a11_over_det(res_out[0]), .slot1_a21_over_det(res_out[1]),
		.slot2_a31_over_det(res_out[2]), .slot3_a12_over_det(res_out[3]),
		.slot4_a22_over_det(res_out[4]), .slot5_a32_over_det(res_out[5]),
		.slot6_a13_over_det(res_out[6]), .slot7_a23_over_det(res_out[7]),
		.slot8_a33_over_det(res_out[8]),
		.scaled_first(res_out[9]), .scaled_second(res_out[10])
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_point(pt_in);
		if (arst_n && done)
			sb.check_result(res_out);
	end

	task send_point(input point_t pt);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pt_in <= pt;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
	endtask

	function logic [31:0] rand_field();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
			2: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
			3: return $urandom_range(32'h1000) - 32'h800;
			default: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
		endcase
	endfunction

	function point_t rand_point();
		point_t pt;
		for (int i = 0; i < 12; i++)
			pt[i] = rand_field();
		case ($urandom_range(7))
			0: begin
				// singular: a repeated column
				pt[3] = pt[0];
				pt[4] = pt[1];
				pt[5] = pt[2];
			end
			1: begin
				// singular: a zero row
				pt[1] = '0;
				pt[4] = '0;
				pt[7] = '0;
			end
			2: begin
				pt[1] = '0; pt[2] = '0; pt[3] = '0;
				pt[5] = '0; pt[6] = '0; pt[7] = '0;
			end
			default: ;
		endcase
		return pt;
	endfunction

	function point_t diag_point(input logic [31:0] d, input logic [31:0] w,
			input logic [31:0] c);
		point_t pt;
		pt = '0;
		pt[0] = d; pt[4] = d; pt[8] = d;
		pt[9] = w; pt[10] = c; pt[11] = -c;
		return pt;
	endfunction

	task drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		point_t pt;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		pt_in = '0;
		idle_pct = 0;
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_point(diag_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
		send_point('0);
		send_point('1);
		send_point({12{32'h7FFF_FFFF}});
		send_point({12{32'h8000_0000}});
		send_point(diag_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		send_point(diag_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
		send_point(diag_point(32'h0000_0001, 32'h0001_0000, 32'h0001_0000));
		send_point(diag_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001));
		send_point(diag_point(32'h0002_0000, 32'h0, 32'h0003_0000));
		send_point(diag_point(32'hFFFE_0000, 32'h0000_8000, 32'hFFFF_0000));
		pt = diag_point(32'h0003_0000, 32'h0001_0000, 32'h0001_0000);
		pt[3] = 32'h0001_0000;
		pt[7] = 32'hFFFF_8000;
		send_point(pt);
		pt = {12{32'h5555_AAAA}};
		send_point(pt);
		pt = {12{32'hAAAA_5555}};
		pt[0] = 32'h0;
		send_point(pt);
		drain();

		idle_pct = 20;
		repeat (230) send_point(rand_point());
		drain();
		idle_pct = 55;
		repeat (230) send_point(rand_point());
		idle_pct = 0;
		repeat (230) send_point(rand_point());
		drain();
		repeat (jit_pkg::LAT + 10) @(posedge clk);

		$display("Sent %0d quadrature points, %0d results checked, %0d mismatches.",
			sent, sb.checked, sb.errors);
		$display("Covered identity, zero and singular Jacobians, full-scale and saturating values.");
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/jit_pkg.sv
rtl/core/jit_div_lane.sv
rtl/core/jacobian_inverse_transpose_3x3.sv
test/jacobian_inverse_transpose_3x3_tb.sv
